// File: sv/zone_map_border_detect_macros.svh
// Assertion macros shared by the zone map border detector.
`ifndef ZONE_MAP_BORDER_DETECT_MACROS_SVH
`define ZONE_MAP_BORDER_DETECT_MACROS_SVH

// The condition must never be seen at a clock edge outside reset.
`define ZMBD_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

// When the first expression holds, the second must hold in the following cycle.
`define ZMBD_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: sv/zmbd_pkg.sv
// Types and constants shared by the zone map border detector modules.
package zmbd_pkg;

   // Fixed field widths of the streams and the register port.
   localparam int COL_OUT_BITS   = 12;
   localparam int ROW_OUT_BITS   = 12;
   localparam int FLAG_BITS      = 8;
   localparam int LEVEL_OUT_BITS = 3;
   localparam int CFG_BITS       = 13;
   localparam int ROW_BITS       = 13;

   // Map size limits and reset value.
   localparam int MIN_SIZE   = 2;
   localparam int MAX_HEIGHT = 4096;
   localparam int RESET_SIZE = 256;
   localparam logic [ROW_BITS-1:0] ROW_CAP = 13'd8191;

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      CSR_MAP_WIDTH  = 2'd0,
      CSR_MAP_HEIGHT = 2'd1
   } csr_index_type;

   // Input item kind carried in tuser.
   localparam logic ACTION_DRAIN = 1'b1;

   // Bit positions in the border flags.
   localparam int FLAG_SIDE_WEST    = 0;
   localparam int FLAG_SIDE_NORTH   = 1;
   localparam int FLAG_SIDE_EAST    = 2;
   localparam int FLAG_SIDE_SOUTH   = 3;
   localparam int FLAG_CORNER_NW    = 4;
   localparam int FLAG_CORNER_SW    = 5;
   localparam int FLAG_CORNER_SE    = 6;
   localparam int FLAG_CORNER_NE    = 7;

   // Result queue sizing.
   localparam int RSP_DEPTH     = 3;
   localparam int RSP_PTR_BITS  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS  = $clog2(RSP_DEPTH + 1);

   // One result item.
   typedef struct packed {
      logic                      frame_last;
      logic [LEVEL_OUT_BITS-1:0] center_level;
      logic [FLAG_BITS-1:0]      border_flags;
      logic [ROW_OUT_BITS-1:0]   tile_row;
      logic [COL_OUT_BITS-1:0]   tile_column;
   } rsp_item_type;

   // Fill state of the result queue.
   typedef struct packed {
      logic                    not_empty;
      logic [RSP_CNT_BITS-1:0] count;
   } rsp_queue_status_type;

endpackage

// File: sv/zmbd_line_store.sv
// Upper and middle line stores with registered read and write-to-read forwarding.
module zmbd_line_store #(
   parameter int DEPTH     = 4096,
   parameter int DATA_BITS = 3
) (
   input  logic                       clock,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_BITS-1:0]       wr_upper,
   input  logic [DATA_BITS-1:0]       wr_middle,
   output logic [DATA_BITS-1:0]       rd_upper,
   output logic [DATA_BITS-1:0]       rd_middle
);

   logic [DATA_BITS-1:0] mem_upper_ff  [DEPTH];
   logic [DATA_BITS-1:0] mem_middle_ff [DEPTH];
   logic [DATA_BITS-1:0] q_upper_ff;
   logic [DATA_BITS-1:0] q_middle_ff;
   logic                 fwd_ff;
   logic [DATA_BITS-1:0] fwd_upper_ff;
   logic [DATA_BITS-1:0] fwd_middle_ff;

   // Both stores share one address per access; the read is taken every cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_upper_ff[wr_addr]  <= wr_upper;
         mem_middle_ff[wr_addr] <= wr_middle;
      end
      q_upper_ff  <= mem_upper_ff[rd_addr];
      q_middle_ff <= mem_middle_ff[rd_addr];
   end

   // A read of the entry being written in the same cycle takes the new data.
   always_ff @(posedge clock) begin
      fwd_ff        <= wr_en && (wr_addr == rd_addr);
      fwd_upper_ff  <= wr_upper;
      fwd_middle_ff <= wr_middle;
   end

   assign rd_upper  = fwd_ff ? fwd_upper_ff  : q_upper_ff;
   assign rd_middle = fwd_ff ? fwd_middle_ff : q_middle_ff;

endmodule

// File: sv/zmbd_rsp_queue.sv
// Small result queue that decouples the flag stage from the result channel.
module zmbd_rsp_queue import zmbd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rsp_item_type         push_item,
   input  logic                 pop,
   output rsp_item_type         head_item,
   output rsp_queue_status_type status
);

   rsp_item_type            entries_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ptr_ff;
   logic [RSP_PTR_BITS-1:0] wr_ptr_in;
   logic [RSP_PTR_BITS-1:0] rd_ptr_ff;
   logic [RSP_PTR_BITS-1:0] rd_ptr_in;
   logic [RSP_CNT_BITS-1:0] count_ff;
   logic [RSP_CNT_BITS-1:0] count_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == RSP_PTR_BITS'(RSP_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + RSP_PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == RSP_PTR_BITS'(RSP_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + RSP_PTR_BITS'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + RSP_CNT_BITS'(1);
         2'b01:   count_in = count_ff - RSP_CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Item storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item        = entries_ff[rd_ptr_ff];
   assign status.count     = count_ff;
   assign status.not_empty = (count_ff != '0);

endmodule

// File: sv/zone_map_border_detect.sv
// Top level of the zone map border detector: counters, window and flag logic.
//
// Channel  Handshake                Payload
// req      req_tvalid, req_tready   tdata: zone_level; tuser: action
// rsp      rsp_tvalid, rsp_tready   tdata: column, row, flags, level; tlast: frame_last
// csr      csr_valid, csr_ready     csr_index, csr_data
//
// One item is taken every clock while req_tready is high; each result passes the line
// store read, then the window and flag stage, then the result queue on its way out.
// The line stores give one read and one write per cycle, which sets the rate.
// Reset is synchronous and clears counters, window and queue, and sets both sizes
// to 256; the line stores are not cleared, as unwritten entries are never used.
// req_tready drops while the flag stage and the three-entry queue hold three items.
`include "zone_map_border_detect_macros.svh"

module zone_map_border_detect import zmbd_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int LEVEL_BITS = 3
) (
   input  logic                clock,
   input  logic                reset,
   // Tile stream
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [2:0] zone_level
   input  logic                req_tuser,   // [0] action
   // Result stream
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [39:0]         rsp_tdata,   // [11:0] tile_column, [23:12] tile_row,
                                            // [31:24] border_flags, [34:32] center_level
   output logic                rsp_tlast,   // frame_last
   // Register writes
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [CFG_BITS-1:0] csr_data
);

   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int WID_BITS    = $clog2(MAX_WIDTH + 1);
   localparam int LV          = (LEVEL_BITS < LEVEL_OUT_BITS) ? LEVEL_BITS : LEVEL_OUT_BITS;
   localparam int RESET_WIDTH = (RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : RESET_SIZE;

   // Map size registers, held already clamped.
   logic [WID_BITS-1:0] width_ff;
   logic [WID_BITS-1:0] width_in;
   logic [ROW_BITS-1:0] height_ff;
   logic [ROW_BITS-1:0] height_in;

   // Stream position counters.
   logic [COL_BITS-1:0]     in_col_ff;
   logic [COL_BITS-1:0]     in_col_in;
   logic [ROW_BITS-1:0]     in_row_ff;
   logic [ROW_BITS-1:0]     in_row_in;
   logic [COL_BITS-1:0]     out_col_ff;
   logic [COL_BITS-1:0]     out_col_in;
   logic [ROW_OUT_BITS-1:0] out_row_ff;
   logic [ROW_OUT_BITS-1:0] out_row_in;

   // Accept stage signals.
   logic                in_frame;
   logic                take;
   logic                go;
   logic [LV-1:0]       lvl0;
   logic                emit0;
   logic                last0;
   logic [WID_BITS-1:0] in_col_inc;
   logic [WID_BITS-1:0] out_col_inc;
   logic [ROW_BITS-1:0] out_row_inc;
   logic [2:0]          rowok0;
   logic [2:0]          colok0;

   // Flag stage registers.
   logic                    s1_valid_ff;
   logic                    s1_emit_ff;
   logic                    s1_last_ff;
   logic [COL_BITS-1:0]     s1_idx_ff;
   logic [LV-1:0]           s1_lvl_ff;
   logic [COL_BITS-1:0]     s1_col_ff;
   logic [ROW_OUT_BITS-1:0] s1_row_ff;
   logic [2:0]              s1_rowok_ff;
   logic [2:0]              s1_colok_ff;

   // Window and line store data.
   logic [LV-1:0] win_ff [3][3];
   logic [LV-1:0] win_in [3][3];
   logic [LV-1:0] cv     [3][3];
   logic [LV-1:0] ls_upper;
   logic [LV-1:0] ls_middle;
   logic [LV-1:0] z;
   logic [LV-1:0] tr;
   logic [LV-1:0] tl;
   logic [LV-1:0] bl;
   logic [LV-1:0] br;
   logic [FLAG_BITS-1:0] flags;

   // Result queue.
   rsp_item_type         push_item;
   rsp_item_type         head_item;
   rsp_queue_status_type q_status;
   logic                 q_push;
   logic                 rsp_pop;

   // Conditions watched by the checks.
   logic                 q_overflow;
   logic                 frame_end;
   logic                 cnt_clear;
   logic                 lvl0_flagged;

   // Register writes are always taken; sizes are clamped on the way in.
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAP_WIDTH: begin
               if (csr_data < CFG_BITS'(MIN_SIZE)) begin
                  width_in = WID_BITS'(MIN_SIZE);
               end else if (32'(csr_data) > MAX_WIDTH) begin
                  width_in = WID_BITS'(MAX_WIDTH);
               end else begin
                  width_in = WID_BITS'(csr_data);
               end
            end
            CSR_MAP_HEIGHT: begin
               if (csr_data < CFG_BITS'(MIN_SIZE)) begin
                  height_in = ROW_BITS'(MIN_SIZE);
               end else if (csr_data > CFG_BITS'(MAX_HEIGHT)) begin
                  height_in = ROW_BITS'(MAX_HEIGHT);
               end else begin
                  height_in = csr_data;
               end
            end
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WID_BITS'(RESET_WIDTH);
         height_ff <= ROW_BITS'(RESET_SIZE);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // The flag stage and queue together never hold more than the queue depth.
   assign req_tready = (3'(q_status.count) + 3'(s1_valid_ff)) < 3'(RSP_DEPTH);

   // Accept stage: item kind, emit and frame end decisions, next positions.
   always_comb begin
      in_frame    = in_row_ff < height_ff;
      take        = req_tvalid && req_tready;
      go          = take && !(in_frame && (req_tuser == ACTION_DRAIN));
      lvl0        = in_frame ? LV'(req_tdata[LEVEL_OUT_BITS-1:0]) : '0;
      in_col_inc  = WID_BITS'(in_col_ff) + WID_BITS'(1);
      out_col_inc = WID_BITS'(out_col_ff) + WID_BITS'(1);
      out_row_inc = ROW_BITS'(out_row_ff) + ROW_BITS'(1);
      emit0       = (in_row_ff >= ROW_BITS'(2)) ||
                    ((in_row_ff == ROW_BITS'(1)) && (in_col_ff != '0));
      last0       = (out_col_inc >= width_ff) && (out_row_inc >= height_ff);

      // Which window rows and columns lie inside the map; after a size change
      // the described tile may itself lie beyond the new edge.
      rowok0[0] = (out_row_ff != '0) && (ROW_BITS'(out_row_ff) <= height_ff);
      rowok0[1] = ROW_BITS'(out_row_ff) < height_ff;
      rowok0[2] = out_row_inc < height_ff;
      colok0[0] = (out_col_ff != '0) && (WID_BITS'(out_col_ff) <= width_ff);
      colok0[1] = WID_BITS'(out_col_ff) < width_ff;
      colok0[2] = out_col_inc < width_ff;

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (go) begin
         if (in_col_inc >= width_ff) begin
            in_col_in = '0;
            if (in_row_ff < ROW_CAP) begin
               in_row_in = in_row_ff + ROW_BITS'(1);
            end
         end else begin
            in_col_in = COL_BITS'(in_col_inc);
         end
         if (emit0) begin
            if (last0) begin
               // Frame end: the next item starts a new map.
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_inc >= width_ff) begin
               out_col_in = '0;
               out_row_in = ROW_OUT_BITS'(out_row_inc);
            end else begin
               out_col_in = COL_BITS'(out_col_inc);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         s1_valid_ff <= go;
      end
   end

   // Item details carried into the flag stage.
   always_ff @(posedge clock) begin
      if (go) begin
         s1_emit_ff  <= emit0;
         s1_last_ff  <= emit0 && last0;
         s1_idx_ff   <= in_col_ff;
         s1_lvl_ff   <= lvl0;
         s1_col_ff   <= out_col_ff;
         s1_row_ff   <= out_row_ff;
         s1_rowok_ff <= rowok0;
         s1_colok_ff <= colok0;
      end
   end

   // Line stores: read at the accept stage, written back in the flag stage.
   zmbd_line_store #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (LV)
   ) u_line_store (
      .clock     (clock),
      .rd_addr   (in_col_ff),
      .wr_en     (s1_valid_ff),
      .wr_addr   (s1_idx_ff),
      .wr_upper  (ls_middle),
      .wr_middle (s1_lvl_ff),
      .rd_upper  (ls_upper),
      .rd_middle (ls_middle)
   );

   // Window shifts left and takes the new column from the line stores and the new item.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
      end
      win_in[0][2] = ls_upper;
      win_in[1][2] = ls_middle;
      win_in[2][2] = s1_lvl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= s1_last_ff ? '0 : win_in[r][c];
            end
         end
      end
   end

   // Border flags on the shifted window; positions off the map read as level 0.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            cv[r][c] = (s1_rowok_ff[r] && s1_colok_ff[c]) ? win_in[r][c] : '0;
         end
      end
      z     = cv[1][1];
      tr    = cv[1][0];
      tl    = cv[0][1];
      bl    = cv[1][2];
      br    = cv[2][1];
      flags = '0;
      if (z != '0) begin
         flags[FLAG_SIDE_WEST]  = tr < z;
         flags[FLAG_SIDE_NORTH] = tl < z;
         flags[FLAG_SIDE_EAST]  = bl < z;
         flags[FLAG_SIDE_SOUTH] = br < z;
         flags[FLAG_CORNER_NW]  = (tr == z) && (tl == z) && (cv[0][0] < z);
         flags[FLAG_CORNER_SW]  = (tr == z) && (br == z) && (cv[2][0] < z);
         flags[FLAG_CORNER_SE]  = (br == z) && (bl == z) && (cv[2][2] < z);
         flags[FLAG_CORNER_NE]  = (tl == z) && (bl == z) && (cv[0][2] < z);
      end
   end

   // Result item into the queue.
   always_comb begin
      q_push                 = s1_valid_ff && s1_emit_ff;
      push_item.tile_column  = COL_OUT_BITS'(s1_col_ff);
      push_item.tile_row     = s1_row_ff;
      push_item.border_flags = flags;
      push_item.center_level = LEVEL_OUT_BITS'(z);
      push_item.frame_last   = s1_last_ff;
   end

   assign rsp_pop = rsp_tvalid && rsp_tready;

   zmbd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (rsp_pop),
      .head_item (head_item),
      .status    (q_status)
   );

   // Result channel.
   assign rsp_tvalid = q_status.not_empty;
   assign rsp_tdata  = {5'b0, head_item.center_level, head_item.border_flags,
                        head_item.tile_row, head_item.tile_column};
   assign rsp_tlast  = head_item.frame_last;

   // Checks.
   assign q_overflow   = q_push && !rsp_pop && (q_status.count == RSP_CNT_BITS'(RSP_DEPTH));
   assign frame_end    = go && emit0 && last0;
   assign cnt_clear    = (out_col_ff == '0) && (out_row_ff == '0) && (in_row_ff == '0);
   assign lvl0_flagged = q_push && (push_item.center_level == '0) &&
                         (push_item.border_flags != '0);

   `ZMBD_ASSERT_NEVER(a_queue_no_overflow, clock, reset, q_overflow, "result queue overflow")
   `ZMBD_ASSERT_NEXT(a_frame_restart, clock, reset, frame_end, cnt_clear, "counters not cleared")
   `ZMBD_ASSERT_NEVER(a_level0_no_flags, clock, reset, lvl0_flagged, "flags on a level-0 tile")

endmodule

// File: tb/tb_zone_map_border_detect.sv
// Self-checking testbench for the zone map border detector.
module tb_zone_map_border_detect import zmbd_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W         = 4096;
   localparam int RANDOM_ITEMS  = 400;
   localparam int BIG_ROW_TILES = 40;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int DIRECTED_ROWS = 22;

   // Item kinds on the tile stream and a register index the block does not decode.
   localparam logic       ACTION_TILE  = 1'b0;
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   // One row of the directed stimulus, with an optional hand-written result.
   typedef struct packed {
      logic         action;
      logic [2:0]   level;
      logic         typed;
      rsp_item_type want;
   } stim_row_type;

   // Receiver stall patterns.
   typedef enum int {FLOW_FREE, FLOW_COIN, FLOW_THIRDS, FLOW_RARE} flow_mode_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [7:0]          req_tdata;   // [2:0] zone_level
   logic                req_tuser;   // [0] action
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [39:0]         rsp_tdata;   // [11:0] tile_column, [23:12] tile_row,
                                     // [31:24] border_flags, [34:32] center_level
   logic                rsp_tlast;   // frame_last
   logic                csr_valid;
   logic                csr_ready;
   logic [1:0]          csr_index;
   logic [CFG_BITS-1:0] csr_data;

   // Predicted state of the detector.
   logic [CFG_BITS-1:0] width_reg;
   logic [CFG_BITS-1:0] height_reg;
   logic [2:0]          upper_row_store [MAX_W];
   logic [2:0]          middle_row_store [MAX_W];
   logic [2:0]          window_levels [3][3];
   int                  in_col, in_row, out_col, out_row;
   logic [2:0]          last_level;
   bit                  map_finished;

   // Border results still owed by the block, oldest first.
   rsp_item_type        pending_borders [$];

   int                  burst_left;
   int                  tiles_taken, flushes_taken, maps_closed, results_seen, mismatches;
   longint              cycle_count;
   stim_row_type        directed_rows [DIRECTED_ROWS];

   zone_map_border_detect #(
      .MAX_WIDTH (MAX_W),
      .LEVEL_BITS(3)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Map size as the block uses it, clamped to its legal range.
   function automatic int used_size(logic [CFG_BITS-1:0] value, int top);
      if (value < MIN_SIZE) return MIN_SIZE;
      if (value > top) return top;
      return int'(value);
   endfunction

   // Level of a window position, zero where it falls outside the map.
   function automatic logic [2:0] neighbour(int r, int c, int w, int h);
      int y, x;
      y = out_row + r - 1;
      x = out_col + c - 1;
      if (y < 0 || x < 0 || y >= h || x >= w) return 3'd0;
      return window_levels[r][c];
   endfunction

   // Random level, biased towards repeating the tile above or to the left so
   // that equal neighbours, and hence corner flags, turn up often.
   function automatic logic [2:0] pick_level();
      case ($urandom_range(0, 3))
         0: return middle_row_store[in_col < MAX_W ? in_col : MAX_W - 1];
         1: return last_level;
         default: return 3'($urandom_range(0, 7));
      endcase
   endfunction

   // Advance the predicted state by one accepted item and work out its result.
   task automatic predict_border(input logic action, input logic [2:0] level_in,
                                 output bit emitted, output rsp_item_type res);
      int         w, h, idx, r;
      logic [2:0] level, up, mid, z, west, north, east, south;
      logic [7:0] flags;
      bit         fire, is_last;
      w = used_size(width_reg, MAX_W);
      h = used_size(height_reg, MAX_HEIGHT);
      emitted = 1'b0;
      res = '0;
      // Tiles are still expected: a drain is ignored. Past the map end every
      // item flushes with level zero.
      if (in_row < h) begin
         if (action == ACTION_DRAIN) return;
         level = level_in;
         tiles_taken++;
      end else begin
         level = 3'd0;
         flushes_taken++;
      end
      last_level = level;

      // Line stores and window shift.
      idx = in_col < MAX_W ? in_col : MAX_W - 1;
      up = upper_row_store[idx];
      mid = middle_row_store[idx];
      upper_row_store[idx] = mid;
      middle_row_store[idx] = level;
      for (r = 0; r < 3; r++) begin
         window_levels[r][0] = window_levels[r][1];
         window_levels[r][1] = window_levels[r][2];
      end
      window_levels[0][2] = up;
      window_levels[1][2] = mid;
      window_levels[2][2] = level;

      fire = in_row >= 2 || (in_row == 1 && in_col >= 1);
      if (in_col + 1 >= w) begin
         in_col = 0;
         if (in_row < int'(ROW_CAP)) in_row++;
      end else begin
         in_col++;
      end
      if (!fire) return;

      // Side flags where the neighbour is lower, corner flags where both
      // adjacent sides match the centre and the diagonal is lower.
      z = neighbour(1, 1, w, h);
      flags = '0;
      if (z != 3'd0) begin
         west  = neighbour(1, 0, w, h);
         north = neighbour(0, 1, w, h);
         east  = neighbour(1, 2, w, h);
         south = neighbour(2, 1, w, h);
         flags[FLAG_SIDE_WEST]  = west < z;
         flags[FLAG_SIDE_NORTH] = north < z;
         flags[FLAG_SIDE_EAST]  = east < z;
         flags[FLAG_SIDE_SOUTH] = south < z;
         flags[FLAG_CORNER_NW]  = west == z && north == z && neighbour(0, 0, w, h) < z;
         flags[FLAG_CORNER_SW]  = west == z && south == z && neighbour(2, 0, w, h) < z;
         flags[FLAG_CORNER_SE]  = south == z && east == z && neighbour(2, 2, w, h) < z;
         flags[FLAG_CORNER_NE]  = north == z && east == z && neighbour(0, 2, w, h) < z;
      end
      is_last = out_col + 1 >= w && out_row + 1 >= h;

      emitted = 1'b1;
      res.tile_column  = 12'(out_col);
      res.tile_row     = 12'(out_row);
      res.border_flags = flags;
      res.center_level = z;
      res.frame_last   = is_last;

      // Output position; the frame end clears counters and window.
      if (is_last) begin
         window_levels = '{default: '{default: 3'd0}};
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
         map_finished = 1'b1;
         maps_closed++;
      end else if (out_col + 1 >= w) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
   endtask

   // Offer one item on the tile stream, in bursts with random gaps between them.
   task automatic send_item(input logic action, input logic [2:0] level,
                            input logic typed, input rsp_item_type want);
      int           gap;
      bit           emitted;
      rsp_item_type res;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {5'd0, level};
      do @(posedge clock); while (!req_tready);
      predict_border(action, level, emitted, res);
      if (emitted) pending_borders.push_back(typed ? want : res);
   endtask

   // Stop sending and wait until every owed result has arrived.
   task automatic hold_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_borders.size() != 0) @(posedge clock);
   endtask

   // Register write, only once the block has gone quiet.
   task automatic write_reg(input logic [1:0] index, input logic [CFG_BITS-1:0] value);
      hold_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_MAP_WIDTH) width_reg = value;
      else if (index == CSR_MAP_HEIGHT) height_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_map_size(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
      write_reg(CSR_MAP_WIDTH, w);
      write_reg(CSR_MAP_HEIGHT, h);
   endtask

   // Feed one whole map and flush it. With noise on, stray drains, tiles after
   // the map end, size changes in mid-map and full pauses are mixed in.
   task automatic run_map(input bit noisy);
      int roll;
      map_finished = 1'b0;
      while (!map_finished) begin
         roll = $urandom_range(0, 99);
         if (in_row >= used_size(height_reg, MAX_HEIGHT)) begin
            send_item((noisy && roll < 25) ? ACTION_TILE : ACTION_DRAIN, pick_level(),
                      1'b0, '0);
         end else if (noisy && roll < 4) begin
            send_item(ACTION_DRAIN, pick_level(), 1'b0, '0);
         end else if (noisy && roll == 4) begin
            set_map_size(CFG_BITS'($urandom_range(2, 9)), CFG_BITS'($urandom_range(2, 6)));
         end else if (noisy && roll == 5) begin
            hold_for_results();
         end else begin
            send_item(ACTION_TILE, pick_level(), 1'b0, '0);
         end
      end
   endtask

   // Receiver: ready follows a stall pattern that is picked anew at random.
   initial begin
      flow_mode_type mode;
      int            span;
      rsp_tready <= 1'b0;
      mode = FLOW_FREE;
      span = 0;
      forever begin
         @(negedge clock);
         if (span == 0) begin
            mode = flow_mode_type'($urandom_range(0, 3));
            span = $urandom_range(8, 64);
         end
         span--;
         case (mode)
            FLOW_FREE:   rsp_tready <= 1'b1;
            FLOW_COIN:   rsp_tready <= $urandom_range(0, 1) == 1;
            FLOW_THIRDS: rsp_tready <= span % 3 == 0;
            default:     rsp_tready <= $urandom_range(0, 7) != 0;
         endcase
      end
   end

   // Result checker and run limit.
   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset) begin
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Run limit of %0d cycles reached", CYCLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end else if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (pending_borders.size() == 0) begin
               $error("Unexpected result item: tdata %h tlast %b", rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               want = pending_borders.pop_front();
               if (rsp_tdata[11:0] !== want.tile_column) begin
                  $error("tile_column: expected %0d, got %0d", want.tile_column,
                         rsp_tdata[11:0]);
                  mismatches++;
               end
               if (rsp_tdata[23:12] !== want.tile_row) begin
                  $error("tile_row: expected %0d, got %0d", want.tile_row, rsp_tdata[23:12]);
                  mismatches++;
               end
               if (rsp_tdata[31:24] !== want.border_flags) begin
                  $error("border_flags: expected %h, got %h", want.border_flags,
                         rsp_tdata[31:24]);
                  mismatches++;
               end
               if (rsp_tdata[34:32] !== want.center_level) begin
                  $error("center_level: expected %0d, got %0d", want.center_level,
                         rsp_tdata[34:32]);
                  mismatches++;
               end
               if (rsp_tlast !== want.frame_last) begin
                  $error("frame_last: expected %b, got %b", want.frame_last, rsp_tlast);
                  mismatches++;
               end
            end
         end
      end
   end

   // Main sequence.
   initial begin
      int i, start_items;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= ACTION_TILE;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_MAP_WIDTH;
      csr_data   <= '0;
      width_reg  = CFG_BITS'(RESET_SIZE);
      height_reg = CFG_BITS'(RESET_SIZE);
      upper_row_store  = '{default: 3'd0};
      middle_row_store = '{default: 3'd0};
      window_levels    = '{default: '{default: 3'd0}};
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      last_level = 3'd0;
      burst_left = 0;
      tiles_taken = 0;
      flushes_taken = 0;
      maps_closed = 0;
      results_seen = 0;
      mismatches = 0;
      cycle_count = 0;

      // Three 2x2 maps. The first is flat at the top level, so its flags can
      // be read straight off: every side facing the map edge is set.
      directed_rows = '{
         '{ACTION_TILE,  3'd7, 1'b0, '0},
         '{ACTION_TILE,  3'd7, 1'b0, '0},
         '{ACTION_TILE,  3'd7, 1'b0, '0},
         '{ACTION_TILE,  3'd7, 1'b1, '{1'b0, 3'd7, 8'h03, 12'd0, 12'd0}},
         '{ACTION_DRAIN, 3'd0, 1'b1, '{1'b0, 3'd7, 8'h06, 12'd0, 12'd1}},
         '{ACTION_DRAIN, 3'd0, 1'b1, '{1'b0, 3'd7, 8'h09, 12'd1, 12'd0}},
         '{ACTION_DRAIN, 3'd0, 1'b1, '{1'b1, 3'd7, 8'h0C, 12'd1, 12'd1}},
         // A drain before any tile is ignored; then a north-west corner on the
         // last tile, and a tile past the map end that only flushes.
         '{ACTION_DRAIN, 3'd5, 1'b0, '0},
         '{ACTION_TILE,  3'd1, 1'b0, '0},
         '{ACTION_TILE,  3'd4, 1'b0, '0},
         '{ACTION_TILE,  3'd4, 1'b0, '0},
         '{ACTION_TILE,  3'd4, 1'b0, '0},
         '{ACTION_TILE,  3'd6, 1'b0, '0},
         '{ACTION_DRAIN, 3'd0, 1'b0, '0},
         '{ACTION_DRAIN, 3'd0, 1'b0, '0},
         // Level-zero tiles carry no flags.
         '{ACTION_TILE,  3'd0, 1'b0, '0},
         '{ACTION_TILE,  3'd5, 1'b0, '0},
         '{ACTION_TILE,  3'd5, 1'b0, '0},
         '{ACTION_TILE,  3'd0, 1'b0, '0},
         '{ACTION_DRAIN, 3'd0, 1'b0, '0},
         '{ACTION_DRAIN, 3'd0, 1'b0, '0},
         '{ACTION_DRAIN, 3'd0, 1'b0, '0}
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part.
      write_reg(CSR_UNMAPPED, CFG_BITS'($urandom_range(0, 8191)));
      set_map_size(2, 2);
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         send_item(directed_rows[i].action, directed_rows[i].level,
                   directed_rows[i].typed, directed_rows[i].want);
      end

      // One quiet map nine tiles wide, so that every line store column the
      // random maps can reach holds a real level before sizes change mid-map.
      set_map_size(9, 2);
      run_map(1'b0);

      // Random small maps, sizes now and then below the legal range.
      start_items = tiles_taken + flushes_taken;
      while (tiles_taken + flushes_taken - start_items < RANDOM_ITEMS) begin
         set_map_size(CFG_BITS'($urandom_range(0, 9) == 0 ? $urandom_range(0, 1) :
                                                            $urandom_range(2, 9)),
                      CFG_BITS'($urandom_range(0, 9) == 0 ? $urandom_range(0, 1) :
                                                            $urandom_range(2, 6)));
         run_map(1'b1);
      end

      // Largest sizes with all register bits set: a short stretch of the first
      // row, then the map shrinks in mid-row and is finished at 3x2.
      set_map_size(8191, 8191);
      for (i = 0; i < BIG_ROW_TILES; i++) begin
         send_item(ACTION_TILE, pick_level(), 1'b0, '0);
      end
      write_reg(CSR_UNMAPPED, CFG_BITS'($urandom_range(0, 8191)));
      set_map_size(3, 2);
      run_map(1'b0);
      set_map_size(1, 0);
      run_map(1'b1);

      hold_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d tiles and %0d flush items over %0d maps, %0d results checked,",
               tiles_taken, flushes_taken, maps_closed, results_seen);
      $display("with maps from 2x2 to 9x6, sizes below range and a 4096x4096 map cut short.");
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/zmbd_pkg.sv
sv/zmbd_line_store.sv
sv/zmbd_rsp_queue.sv
sv/zone_map_border_detect.sv
tb/tb_zone_map_border_detect.sv
